FILE: rtl/matrix_4x4_row_product_core_assert.svh
// Assertion macros for the 4x4 matrix row product core.
`ifndef MATRIX_4X4_ROW_PRODUCT_CORE_ASSERT_SVH
`define MATRIX_4X4_ROW_PRODUCT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MRP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MRP_ASSERT_SAME(label, clk, rst, ante, cons)

`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/mrp_pkg.sv
// Shared types and constants for the 4x4 matrix row product core.
package mrp_pkg;

  localparam int FIELD_W = 32;
  localparam int ROW_W = 2;
  localparam int N = 4;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic opcode;
    logic [ROW_W-1:0] row_index;
    logic signed [FIELD_W-1:0] elem0;
    logic signed [FIELD_W-1:0] elem1;
    logic signed [FIELD_W-1:0] elem2;
    logic signed [FIELD_W-1:0] elem3;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic signed [FIELD_W-1:0] prod0;
    logic signed [FIELD_W-1:0] prod1;
    logic signed [FIELD_W-1:0] prod2;
    logic signed [FIELD_W-1:0] prod3;
  } out_word_t;

  typedef struct packed {
    logic mul;
    logic sum;
    logic res;
  } pipe_en_t;

endpackage

FILE: rtl/mrp_matrix.sv
// Register storage for the right-hand matrix, written one row at a time.
module mrp_matrix #(
  parameter int OP_W = mrp_pkg::FIELD_W
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [mrp_pkg::ROW_W-1:0] wr_row,
  input  logic [mrp_pkg::N-1:0][OP_W-1:0] wr_data,
  output logic [mrp_pkg::N-1:0][mrp_pkg::N-1:0][OP_W-1:0] entries
);

  logic [mrp_pkg::N-1:0][mrp_pkg::N-1:0][OP_W-1:0] mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= '0;
    end else if (wr_en) begin
      mat[wr_row] <= wr_data;
    end
  end

  assign entries = mat;

endmodule

FILE: rtl/mrp_lane.sv
// One output column: four products, their sum, then floor shift and saturation.
module mrp_lane #(
  parameter int OP_W = mrp_pkg::FIELD_W,
  parameter int FRAC_BITS = mrp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  mrp_pkg::pipe_en_t en,
  input  logic [mrp_pkg::N-1:0][OP_W-1:0] a,
  input  logic [mrp_pkg::N-1:0][OP_W-1:0] b,
  output logic signed [mrp_pkg::FIELD_W-1:0] res
);

  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W = PROD_W + 2;

  logic [mrp_pkg::N-1:0][PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-OP_W:0] upper;
  logic signed [OP_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int k = 0; k < mrp_pkg::N; k++) begin
        prod[k] <= $signed(a[k]) * $signed(b[k]);
      end
    end
  end

  always_comb begin
    acc_next = '0;
    for (int k = 0; k < mrp_pkg::N; k++) begin
      acc_next = acc_next + {{2{prod[k][PROD_W-1]}}, prod[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      acc <= acc_next;
    end
  end

  // The arithmetic shift of the exact sum is the floor of the scaled result.
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    upper = shifted[ACC_W-1:OP_W-1];
    if ((&upper) || !(|upper)) begin
      sat = shifted[OP_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat = {1'b1, {(OP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en.res) begin
      res <= mrp_pkg::FIELD_W'(sat);
    end
  end

endmodule

FILE: rtl/matrix_4x4_row_product_core.sv
// Top level of the 4x4 matrix row product core.
//
// Request words arrive on req_valid/req_stall/req_word. A load word stores its four
// elements as one row of the right-hand matrix and returns nothing. A multiply word
// carries one row of the left matrix; the core returns the product row, tagged with
// the word's row_index, on rsp_valid/rsp_stall/rsp_word.
// A word is taken at a rising edge with valid high and stall low.
// Throughput is one word per cycle while req_stall is low. A multiply word passes
// through the operand register, product register, sum register and the output
// register in that order, each one stage. Stages move independently, so empty stages
// close up and the core keeps taking words while results wait, until every stage is
// full and the output is stalled; req_stall then rises.
// A load affects every multiply taken after it, and none taken before it.
// Reset clears the pipeline valid bits and zeroes the stored matrix.
// Elements use the low bits of each field up to the operand width, in signed fixed
// point; results are floored and saturated, then sign-extended to the field width.
`include "matrix_4x4_row_product_core_assert.svh"

module matrix_4x4_row_product_core #(
  parameter int DATA_WIDTH = mrp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = mrp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  mrp_pkg::in_word_t req_word,
  output logic rsp_valid,
  input  logic rsp_stall,
  output mrp_pkg::out_word_t rsp_word
);

  localparam int OP_W = (DATA_WIDTH < mrp_pkg::FIELD_W) ? DATA_WIDTH : mrp_pkg::FIELD_W;

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic en1;
  mrp_pkg::pipe_en_t en;
  logic accept;
  logic [mrp_pkg::N-1:0][OP_W-1:0] in_elems;
  logic [mrp_pkg::N-1:0][OP_W-1:0] a1;
  logic [mrp_pkg::ROW_W-1:0] row1;
  logic [mrp_pkg::ROW_W-1:0] row2;
  logic [mrp_pkg::ROW_W-1:0] row3;
  logic [mrp_pkg::ROW_W-1:0] row4;
  logic [mrp_pkg::N-1:0][mrp_pkg::N-1:0][OP_W-1:0] entries;
  logic [mrp_pkg::N-1:0][mrp_pkg::N-1:0][OP_W-1:0] cols;
  logic [mrp_pkg::N-1:0][mrp_pkg::FIELD_W-1:0] res;

  // A stage takes new contents when it is empty or its contents move on.
  assign en.res = !v4 || !rsp_stall;
  assign en.sum = !v3 || en.res;
  assign en.mul = !v2 || en.sum;
  assign en1 = !v1 || en.mul;

  assign req_stall = !en1;
  assign accept = req_valid && en1;

  assign in_elems[0] = req_word.elem0[OP_W-1:0];
  assign in_elems[1] = req_word.elem1[OP_W-1:0];
  assign in_elems[2] = req_word.elem2[OP_W-1:0];
  assign in_elems[3] = req_word.elem3[OP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept && (req_word.opcode == mrp_pkg::OP_MUL);
      end
      if (en.mul) begin
        v2 <= v1;
      end
      if (en.sum) begin
        v3 <= v2;
      end
      if (en.res) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a1 <= in_elems;
      row1 <= req_word.row_index;
    end
    if (en.mul) begin
      row2 <= row1;
    end
    if (en.sum) begin
      row3 <= row2;
    end
    if (en.res) begin
      row4 <= row3;
    end
  end

  mrp_matrix #(
    .OP_W(OP_W)
  ) u_matrix (
    .clk(clk),
    .rst(rst),
    .wr_en(accept && (req_word.opcode == mrp_pkg::OP_LOAD)),
    .wr_row(req_word.row_index),
    .wr_data(in_elems),
    .entries(entries)
  );

  always_comb begin
    for (int c = 0; c < mrp_pkg::N; c++) begin
      for (int k = 0; k < mrp_pkg::N; k++) begin
        cols[c][k] = entries[k][c];
      end
    end
  end

  for (genvar c = 0; c < mrp_pkg::N; c++) begin : g_lane
    mrp_lane #(
      .OP_W(OP_W),
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .en(en),
      .a(a1),
      .b(cols[c]),
      .res(res[c])
    );
  end

  assign rsp_valid = v4;
  assign rsp_word.out_row = row4;
  assign rsp_word.prod0 = res[0];
  assign rsp_word.prod1 = res[1];
  assign rsp_word.prod2 = res[2];
  assign rsp_word.prod3 = res[3];

  `MRP_ASSERT_SAME(a_stall_only_full, clk, rst, req_stall, v1 && v2 && v3 && v4 && rsp_stall)
  `MRP_ASSERT_NEXT(a_mul_enters, clk, rst, accept && (req_word.opcode == mrp_pkg::OP_MUL), v1)
  `MRP_ASSERT_NEXT(a_load_no_result, clk, rst, accept && (req_word.opcode == mrp_pkg::OP_LOAD), !v1)
  `MRP_ASSERT_NEXT(a_sum_reaches_out, clk, rst, v3 && en.res, rsp_valid)

endmodule

FILE: verif/mrp_row_product_checker.sv
// Checker that predicts and compares product rows on the request and response channels.
module mrp_row_product_checker #(
  parameter int DATA_WIDTH = mrp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = mrp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  mrp_pkg::in_word_t req_word,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  mrp_pkg::out_word_t rsp_word,
  output int fail_count,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrp_pkg::*;

  localparam int OP_W = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

  logic signed [63:0] right_mat [16];
  out_word_t expected_rows [$];

  function automatic logic signed [63:0] to_operand(logic [FIELD_W-1:0] raw);
    logic signed [FIELD_W-1:0] t;
    t = raw << (FIELD_W - OP_W);
    return t >>> (FIELD_W - OP_W);
  endfunction

  function automatic out_word_t product_row(in_word_t w);
    out_word_t r;
    logic signed [65:0] acc, a, b, hi, lo;
    logic signed [63:0] e [4];
    logic [FIELD_W-1:0] col [4];
    e[0] = to_operand(w.elem0);
    e[1] = to_operand(w.elem1);
    e[2] = to_operand(w.elem2);
    e[3] = to_operand(w.elem3);
    hi = 66'sd1;
    hi = (hi <<< (OP_W - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    for (int c = 0; c < N; c++) begin
      acc = '0;
      for (int k = 0; k < N; k++) begin
        a = e[k];
        b = right_mat[k*N + c];
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > hi) begin
        acc = hi;
      end else if (acc < lo) begin
        acc = lo;
      end
      col[c] = acc[FIELD_W-1:0];
    end
    r.out_row = w.row_index;
    r.prod0 = col[0];
    r.prod1 = col[1];
    r.prod2 = col[2];
    r.prod3 = col[3];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    logic [FIELD_W-1:0] got_p [4];
    logic [FIELD_W-1:0] want_p [4];
    if (rst) begin
      fail_count = 0;
      expected_rows.delete();
      foreach (right_mat[i]) right_mat[i] = '0;
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected result word for row %0d", rsp_word.out_row));
        end else begin
          want = expected_rows.pop_front();
          if (rsp_word.out_row !== want.out_row) begin
            report_mismatch($sformatf("out_row: got %0d, expected %0d",
                                      rsp_word.out_row, want.out_row));
          end
          got_p = '{rsp_word.prod0, rsp_word.prod1, rsp_word.prod2, rsp_word.prod3};
          want_p = '{want.prod0, want.prod1, want.prod2, want.prod3};
          for (int c = 0; c < N; c++) begin
            if (got_p[c] !== want_p[c]) begin
              report_mismatch($sformatf("row %0d prod%0d: got %h, expected %h",
                                        want.out_row, c, got_p[c], want_p[c]));
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req_word.opcode == OP_LOAD) begin
          right_mat[req_word.row_index*N + 0] = to_operand(req_word.elem0);
          right_mat[req_word.row_index*N + 1] = to_operand(req_word.elem1);
          right_mat[req_word.row_index*N + 2] = to_operand(req_word.elem2);
          right_mat[req_word.row_index*N + 3] = to_operand(req_word.elem3);
        end else begin
          expected_rows.push_back(product_row(req_word));
        end
      end
      pending <= expected_rows.size();
    end
  end

endmodule

FILE: verif/tb_matrix_4x4_row_product_core.sv
// Testbench top for the 4x4 matrix row product core: stimulus, handshake idling and verdict.
module tb_matrix_4x4_row_product_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mrp_pkg::*;

  localparam logic [FIELD_W-1:0] MAX_V = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] MIN_V = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] ONE_V = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] NEG_V = 32'hFFFF_FFFF;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_word_t req_word;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_word_t rsp_word;
  logic calm = 1'b0;
  int fail_count;
  int pending;

  matrix_4x4_row_product_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word(req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word(rsp_word)
  );

  mrp_row_product_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word(req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word(rsp_word),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < 19);
    end
  end

  function automatic in_word_t make_word(logic op, logic [ROW_W-1:0] row,
                                         logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                         logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d);
    in_word_t w;
    w.opcode = op;
    w.row_index = row;
    w.elem0 = a;
    w.elem1 = b;
    w.elem2 = c;
    w.elem3 = d;
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_elem();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6, 7: v = $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: begin
        case ($urandom_range(5))
          0: v = MAX_V;
          1: v = MIN_V;
          2: v = ONE_V;
          3: v = NEG_V;
          4: v = '0;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_word();
    logic op;
    op = ($urandom_range(99) < 35) ? OP_LOAD : OP_MUL;
    return make_word(op, ROW_W'($urandom_range(3)), rand_elem(), rand_elem(),
                     rand_elem(), rand_elem());
  endfunction

  task automatic send_word(in_word_t w);
    while (!calm && $urandom_range(99) < 19) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req_word <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty matrix, identity, full-scale saturation and floor rounding.
    send_word(make_word(OP_MUL, 2'd0, MAX_V, MIN_V, MAX_V, MIN_V));
    send_word(make_word(OP_LOAD, 2'd0, ONE_V, '0, '0, '0));
    send_word(make_word(OP_LOAD, 2'd1, '0, ONE_V, '0, '0));
    send_word(make_word(OP_LOAD, 2'd2, '0, '0, ONE_V, '0));
    send_word(make_word(OP_LOAD, 2'd3, '0, '0, '0, ONE_V));
    send_word(make_word(OP_MUL, 2'd1, MAX_V, MIN_V, 32'h0000_0001, NEG_V));
    send_word(make_word(OP_MUL, 2'd2, 32'hFFFF_8000, 32'h0001_8000, 32'h1234_5678, '0));
    send_word(make_word(OP_LOAD, 2'd0, MAX_V, MAX_V, MAX_V, MAX_V));
    send_word(make_word(OP_LOAD, 2'd1, MAX_V, MAX_V, MAX_V, MAX_V));
    send_word(make_word(OP_LOAD, 2'd2, MIN_V, MIN_V, MIN_V, MIN_V));
    send_word(make_word(OP_LOAD, 2'd3, MIN_V, MIN_V, MIN_V, MIN_V));
    send_word(make_word(OP_MUL, 2'd3, MAX_V, MAX_V, MIN_V, MIN_V));
    send_word(make_word(OP_MUL, 2'd0, MIN_V, MIN_V, MAX_V, MAX_V));
    send_word(make_word(OP_MUL, 2'd1, MAX_V, MAX_V, MAX_V, MAX_V));
    send_word(make_word(OP_LOAD, 2'd0, 32'h0000_0001, 32'h0000_0001,
                        32'h0000_0001, 32'h0000_0001));
    send_word(make_word(OP_LOAD, 2'd1, '0, '0, '0, '0));
    send_word(make_word(OP_LOAD, 2'd2, '0, '0, '0, '0));
    send_word(make_word(OP_LOAD, 2'd3, '0, '0, '0, '0));
    send_word(make_word(OP_MUL, 2'd2, NEG_V, MAX_V, MIN_V, '0));
    send_word(make_word(OP_MUL, 2'd3, 32'h0000_0001, '0, '0, '0));
    send_word(make_word(OP_MUL, 2'd0, MIN_V, '0, '0, '0));
    drain_results();

    for (int i = 0; i < 800; i++) begin
      if (i == 250) calm <= 1'b1;
      if (i == 400) calm <= 1'b0;
      if (i == 600) drain_results();
      send_word(rand_word());
    end
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("matrix_4x4_row_product_core regression: pass");
    end else begin
      $display("matrix_4x4_row_product_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("matrix_4x4_row_product_core regression: fail");
    $finish;
  end

endmodule
